// ----- src/motor_feedback_angle_unwrap_assert.svh -----
// ---------------------------------------------------------------------------
// motor_feedback_angle_unwrap_assert.svh
// assertion macros shared by the angle unwrap rtl
// ---------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_ANGLE_UNWRAP_ASSERT_SVH
`define MOTOR_FEEDBACK_ANGLE_UNWRAP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MFAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define MFAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/mfau_pkg.sv -----
// ---------------------------------------------------------------------------
// mfau_pkg
// types and constants of the motor feedback angle unwrap
// ---------------------------------------------------------------------------
package mfau_pkg;

  localparam int unsigned IdW        = 11;
  localparam int unsigned EncW       = 16;
  localparam int unsigned TurnW      = 19;
  localparam int unsigned AngleW     = 32;
  localparam int unsigned ScaledW    = 64;
  localparam int unsigned TempW      = 8;
  localparam int unsigned MSlotW     = 3;
  // wide enough for any slot sum and any memory index in the parameter range
  localparam int unsigned SlotSumW   = 5;
  localparam int unsigned TurnShift  = 13;
  localparam int unsigned TotW       = 33;

  localparam logic [IdW-1:0]          BaseIdReset = 11'd513;
  localparam logic signed [EncW:0]    HalfTurnPos = 17'sd4096;
  localparam logic signed [EncW:0]    HalfTurnNeg = -17'sd4096;
  localparam logic signed [TurnW-1:0] TurnMax     = 19'sd262143;
  localparam logic signed [TurnW-1:0] TurnMin     = -19'sd262144;

  // result of the identifier decode
  typedef struct packed {
    logic                match;
    logic [SlotSumW-1:0] slot;
  } slot_dec_t;

  // one entry of the per-motor state memory
  typedef struct packed {
    logic [EncW-1:0]         start_offset;
    logic [EncW-1:0]         prev_enc;
    logic signed [TurnW-1:0] turns;
  } state_entry_t;

endpackage

// ----- src/motor_feedback_angle_unwrap.sv -----
// ---------------------------------------------------------------------------
// motor_feedback_angle_unwrap
// multi-turn encoder unwrap for received motor feedback frames
// ---------------------------------------------------------------------------
// Input stream: one received frame per item, tuser is the bus, tdata the
// identifier and eight payload bytes. Frames outside the motor identifier
// range are consumed in the idle state and give no result.
// Output stream: one item per matching frame, tuser is the motor slot, tdata
// the unpacked fields, turn count, unwrapped angle and scaled angle.
// Config channel: writes the base identifier; write only while idle.
// A matching frame passes the lookup and scale steps before its result is loaded.
// A new frame waits until a matching frame is done: read the per-motor state
// memory on accept, update and write back in the lookup step, then scale.
// tready is low while a matching frame is being worked on.
// Reset: base identifier returns to 513 and all per-motor valid bits clear,
// so every slot starts over at once, with no clearing pass.
// Stall: the result sits in the output register until taken; a following
// matching frame waits in the scale step until the output register is free,
// and tready stays low until it has moved on.
// ---------------------------------------------------------------------------
module motor_feedback_angle_unwrap
  import mfau_pkg::*;
#(
  parameter int unsigned MOTORS_PER_BUS = 4,
  parameter int unsigned BUS_COUNT      = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // config write channel
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [IdW-1:0] cfg_data_i,     // base_identifier
  // frame input
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [79:0]    s_axis_tdata,   // frame_identifier, frame_payload, zero pad
  input  logic           s_axis_tuser,   // bus_number
  // result output
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [175:0]   m_axis_tdata,   // encoder_value, speed_value, current_value,
                                         // temperature_value, turn_count,
                                         // unwrapped_angle, scaled_angle, zero pad
  output logic [2:0]     m_axis_tuser    // motor_slot
);

  localparam int unsigned SlotCount = MOTORS_PER_BUS * BUS_COUNT;
  localparam int unsigned IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCALE
  } state_e;

  state_e                     state_q;
  logic [IdW-1:0]             base_q;
  slot_dec_t                  dec;
  logic                       in_fire;
  logic [IdxW-1:0]            rd_idx;

  // per-motor state
  state_entry_t               mem_q [SlotCount];
  state_entry_t               rd_q;
  logic [SlotCount-1:0]       taken_q;
  logic                       taken_rd_q;

  // stage registers of the item in flight
  logic [IdxW-1:0]            idx_q;
  logic [MSlotW-1:0]          mslot_q;
  logic [EncW-1:0]            enc_q;
  logic [EncW-1:0]            speed_q;
  logic [EncW-1:0]            cur_q;
  logic [TempW-1:0]           temp_q;
  logic signed [TurnW-1:0]    turns_q;
  logic signed [AngleW-1:0]   total_q;

  // update logic
  state_entry_t               cur_entry;
  state_entry_t               new_entry;
  logic signed [EncW:0]       delta;
  logic signed [EncW:0]       enc_rel;
  logic signed [TurnW-1:0]    turns_new;
  logic signed [TurnW-1:0]    turns_step;
  logic                       step_ok;
  logic signed [TotW-1:0]     total_wide;
  logic signed [AngleW-1:0]   total_sat;
  logic signed [ScaledW-1:0]  total_ext;
  logic signed [ScaledW-1:0]  scaled;
  logic                       out_free;
  logic                       out_load;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseIdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // identifier decode
  mfau_id_match #(
    .MOTORS_PER_BUS(MOTORS_PER_BUS),
    .BUS_COUNT     (BUS_COUNT)
  ) u_id_match (
    .bus_i  (s_axis_tuser),
    .ident_i(s_axis_tdata[10:0]),
    .base_i (base_q),
    .dec_o  (dec)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rd_idx        = dec.slot[IdxW-1:0];

  // state memory: read on accept, write back in the lookup step
  always_ff @(posedge clk_i) begin
    if (in_fire && dec.match) begin
      rd_q <= mem_q[rd_idx];
    end
    if (state_q == ST_LOOKUP) begin
      mem_q[idx_q] <= new_entry;
    end
  end

  // first-frame valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (state_q == ST_LOOKUP) begin
      taken_q[idx_q] <= 1'b1;
    end
  end

  // capture the frame fields on accept, turn count and total in the lookup step
  always_ff @(posedge clk_i) begin
    if (in_fire && dec.match) begin
      idx_q      <= rd_idx;
      mslot_q    <= dec.slot[MSlotW-1:0];
      taken_rd_q <= taken_q[rd_idx];
      enc_q      <= s_axis_tdata[74:59];
      speed_q    <= s_axis_tdata[58:43];
      cur_q      <= s_axis_tdata[42:27];
      temp_q     <= s_axis_tdata[26:19];
    end
    if (state_q == ST_LOOKUP) begin
      turns_q <= turns_new;
      total_q <= total_sat;
    end
  end

  // first frame of a slot starts from this encoder value and zero turns
  always_comb begin
    if (taken_rd_q) begin
      cur_entry = rd_q;
    end else begin
      cur_entry.start_offset = enc_q;
      cur_entry.prev_enc     = enc_q;
      cur_entry.turns        = '0;
    end
  end

  // turn count step with saturation
  assign delta = $signed({1'b0, enc_q}) - $signed({1'b0, cur_entry.prev_enc});

  always_comb begin
    turns_new = cur_entry.turns;
    if (delta > HalfTurnPos) begin
      if (cur_entry.turns != TurnMin) begin
        turns_new = cur_entry.turns - 19'sd1;
      end
    end else if (delta < HalfTurnNeg) begin
      if (cur_entry.turns != TurnMax) begin
        turns_new = cur_entry.turns + 19'sd1;
      end
    end
  end

  assign turns_step = turns_new - cur_entry.turns;
  assign step_ok    = (turns_step == 19'sd0) || (turns_step == 19'sd1) ||
                      (turns_step == -19'sd1);

  always_comb begin
    new_entry.start_offset = cur_entry.start_offset;
    new_entry.prev_enc     = enc_q;
    new_entry.turns        = turns_new;
  end

  // total angle, saturated to 32 bits
  assign enc_rel    = $signed({1'b0, enc_q}) - $signed({1'b0, cur_entry.start_offset});
  assign total_wide = $signed({turns_new, {TurnShift{1'b0}}}) + TotW'(enc_rel);

  always_comb begin
    if (total_wide[TotW-1] == total_wide[TotW-2]) begin
      total_sat = total_wide[AngleW-1:0];
    end else if (total_wide[TotW-1]) begin
      total_sat = {1'b1, {(AngleW-1){1'b0}}};
    end else begin
      total_sat = {1'b0, {(AngleW-1){1'b1}}};
    end
  end

  // times ten as eight plus two
  assign total_ext = ScaledW'(total_q);
  assign scaled    = (total_ext <<< 3) + (total_ext <<< 1);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign out_load  = (state_q == ST_SCALE) && out_free;

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= '0;
    end else begin
      // load a finished item, clear the register once taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= mslot_q;
        m_axis_tdata  <= {5'd0, scaled, total_q, turns_q, temp_q, cur_q, speed_q, enc_q};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire && dec.match) begin
            state_q <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`include "motor_feedback_angle_unwrap_assert.svh"

  `MFAU_ASSERT_SAME(a_out_from_scale, clk_i, rst_ni, $rose(m_axis_tvalid), $past(out_load))
  `MFAU_ASSERT_NEXT(a_miss_stays_idle, clk_i, rst_ni, in_fire && !dec.match, state_q == ST_IDLE)
  `MFAU_ASSERT_NEXT(a_slot_marked, clk_i, rst_ni, state_q == ST_LOOKUP, taken_q[idx_q])
  `MFAU_ASSERT_SAME(a_turn_step_one, clk_i, rst_ni, state_q == ST_LOOKUP, step_ok)

endmodule

// ----- src/mfau_id_match.sv -----
// ---------------------------------------------------------------------------
// mfau_id_match
// checks a frame's bus and identifier against the motor range, gives slot
// ---------------------------------------------------------------------------
module mfau_id_match
  import mfau_pkg::*;
#(
  parameter int unsigned MOTORS_PER_BUS = 4,
  parameter int unsigned BUS_COUNT      = 2
) (
  input  logic           bus_i,
  input  logic [IdW-1:0] ident_i,
  input  logic [IdW-1:0] base_i,
  output slot_dec_t      dec_o
);

  logic [IdW:0]        diff;
  logic                ident_ok;
  logic                bus_ok;
  logic [SlotSumW-1:0] motor;

  // identifier offset from the base, borrow marks below base
  assign diff     = {1'b0, ident_i} - {1'b0, base_i};
  assign ident_ok = !diff[IdW] && (diff[IdW-1:0] < IdW'(MOTORS_PER_BUS));
  assign bus_ok   = (BUS_COUNT > 1) || !bus_i;
  assign motor    = diff[SlotSumW-1:0];

  // slot is bus times motors per bus plus motor index
  always_comb begin
    dec_o.match = ident_ok && bus_ok;
    if (bus_i) begin
      dec_o.slot = SlotSumW'(MOTORS_PER_BUS) + motor;
    end else begin
      dec_o.slot = motor;
    end
  end

endmodule

// ----- bench/motor_feedback_angle_unwrap_test.sv -----
// ---------------------------------------------------------------------------
// motor_feedback_angle_unwrap_test
// Self-checking bench for the multi-turn angle unwrap. A short table of
// frames covers identifier decode edges, first-frame offset capture, payload
// extremes and half-turn step boundaries. Random phases follow, each under
// its own base identifier (extremes included). They use encoder walks that
// drift and wrap, exact half-turn edges and stray identifiers. Every
// accepted frame runs through a local unwrap predictor, and each output item
// is compared field by field with the oldest predicted result. Both stream
// sides idle and stall at random, and one long output stall backs the block
// up onto its input.
// ---------------------------------------------------------------------------
module motor_feedback_angle_unwrap_test;
  import mfau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FullTurn = 64'sd8192;
  localparam longint AngleMax = 64'sd2147483647;
  localparam longint AngleMin = -64'sd2147483648;
  localparam int     HoldAtFrame = 350;
  localparam int     HoldCycles  = 400;

  // one unpacked result item
  typedef struct {
    logic [MSlotW-1:0]         slot;
    logic [EncW-1:0]           encoder;
    logic signed [EncW-1:0]    speed;
    logic signed [EncW-1:0]    current;
    logic [TempW-1:0]          temperature;
    logic signed [TurnW-1:0]   turns;
    logic signed [AngleW-1:0]  total;
    logic signed [ScaledW-1:0] scaled;
  } unwrap_result_t;

  // one frame to send, with an optional hand-written expectation
  typedef struct {
    logic           bus;
    logic [IdW-1:0] id;
    logic [63:0]    payload;
    bit             typed;
    bit             gives_result;
    unwrap_result_t want;
  } frame_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_THIRD} rx_mode_e;

  logic           clk_i         = 1'b0;
  logic           rst_ni        = 1'b0;
  logic           cfg_valid_i   = 1'b0;
  logic           cfg_ready_o;
  logic [IdW-1:0] cfg_data_i    = '0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [79:0]    s_axis_tdata  = '0;  // frame_identifier, frame_payload, zero pad
  logic           s_axis_tuser  = 1'b0; // bus_number
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [175:0]   m_axis_tdata;        // encoder_value, speed_value, current_value,
                                       // temperature_value, turn_count,
                                       // unwrapped_angle, scaled_angle, zero pad
  logic [2:0]     m_axis_tuser;        // motor_slot

  // predictor copy of the register and the per-slot state
  logic [IdW-1:0] model_base = BaseIdReset;
  bit             slot_seen   [8];
  logic [EncW-1:0] slot_origin [8];
  logic [EncW-1:0] slot_last   [8];
  int             slot_turns  [8];

  unwrap_result_t angles_due[$];
  unwrap_result_t seen_res;
  unwrap_result_t due_res;
  int             bad_fields      = 0;
  int             frames_accepted = 0;

  // sender pacing
  int burst_left = 0;
  int gap_max    = 3;
  int enc_walk [8];

  // receiver pacing
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_tick      = 0;
  int       hold_left    = 0;
  bit       hold_done    = 1'b0;

  motor_feedback_angle_unwrap dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // unwrap one frame against the local slot state, returns 1 on a result
  function automatic bit unwrap_frame(input logic bus, input logic [IdW-1:0] id,
                                      input logic [63:0] payload,
                                      output unwrap_result_t res);
    int              motor;
    int              slot;
    int              delta;
    int              t;
    logic [EncW-1:0] enc;
    longint          total;
    res = '{default: '0};
    if (id < model_base) return 1'b0;
    motor = int'(id) - int'(model_base);
    if (motor >= 4) return 1'b0;
    slot = int'(bus) * 4 + motor;
    enc  = payload[63:48];
    // first frame of a slot pins its offset
    if (!slot_seen[slot]) begin
      slot_seen[slot]   = 1'b1;
      slot_origin[slot] = enc;
      slot_last[slot]   = enc;
    end
    // more than half a turn in one step means a wrap
    delta = int'(enc) - int'(slot_last[slot]);
    t = slot_turns[slot];
    if (delta > int'(HalfTurnPos)) begin
      if (t > int'(TurnMin)) t--;
    end else if (delta < int'(HalfTurnNeg)) begin
      if (t < int'(TurnMax)) t++;
    end
    slot_turns[slot] = t;
    slot_last[slot]  = enc;
    total = longint'(t) * FullTurn + longint'(enc) - longint'(slot_origin[slot]);
    if (total > AngleMax) total = AngleMax;
    if (total < AngleMin) total = AngleMin;
    res.slot        = slot[MSlotW-1:0];
    res.encoder     = enc;
    res.speed       = payload[47:32];
    res.current     = payload[31:16];
    res.temperature = payload[15:8];
    res.turns       = t[TurnW-1:0];
    res.total       = total[AngleW-1:0];
    res.scaled      = total * 10;
    return 1'b1;
  endfunction

  // offer one frame, wait for the handshake, then book its expectation
  task automatic send_frame(input frame_row_t row);
    int             gap;
    bit             hit;
    unwrap_result_t calc;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= row.bus;
    s_axis_tdata  <= {5'd0, row.payload, row.id};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_accepted++;
    hit = unwrap_frame(row.bus, row.id, row.payload, calc);
    if (row.typed) begin
      if (row.gives_result) angles_due.push_back(row.want);
    end else if (hit) begin
      angles_due.push_back(calc);
    end
  endtask

  // stop offering and let every pending result drain out
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_base_id(input logic [IdW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    model_base = value;
    cfg_valid_i <= 1'b0;
  endtask

  // random frames: mostly motor identifiers with drifting encoder walks,
  // the rest stray identifiers, half-turn edges and raw 16-bit encoders
  task automatic send_random_frames(input int count, input int drift);
    frame_row_t row;
    int         walk_slot;
    int         enc;
    for (int i = 0; i < count; i++) begin
      row.bus   = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85)
        row.id = IdW'(int'(model_base) + $urandom_range(0, 3));
      else
        row.id = IdW'($urandom_range(0, 2047));
      walk_slot = (int'(row.bus) * 4 + ((int'(row.id) - int'(model_base)) & 3)) & 7;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
          enc = (enc_walk[walk_slot] + $urandom_range(0, 2000) - 1000 + drift * 1500) & 8191;
        11, 12, 13: begin
          case ($urandom_range(0, 3))
            0:       enc = enc_walk[walk_slot] + 4096;
            1:       enc = enc_walk[walk_slot] - 4096;
            2:       enc = enc_walk[walk_slot] + 4097;
            default: enc = enc_walk[walk_slot] - 4097;
          endcase
          enc = enc & 65535;
        end
        14, 15, 16: enc = $urandom_range(0, 8191);
        default:    enc = $urandom_range(0, 65535);
      endcase
      enc_walk[walk_slot] = enc;
      row.payload      = {enc[15:0], 16'($urandom), 32'($urandom)};
      row.typed        = 1'b0;
      row.gives_result = 1'b0;
      row.want         = '{default: '0};
      send_frame(row);
    end
  endtask

  // output side: changing stall patterns plus one long hold-off
  always @(posedge clk_i) begin
    rx_tick++;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && frames_accepted >= HoldAtFrame) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   m_axis_tready <= 1'b1;
        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  // compare each output item with the oldest predicted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_res.slot        = m_axis_tuser;
      seen_res.encoder     = m_axis_tdata[15:0];
      seen_res.speed       = m_axis_tdata[31:16];
      seen_res.current     = m_axis_tdata[47:32];
      seen_res.temperature = m_axis_tdata[55:48];
      seen_res.turns       = m_axis_tdata[74:56];
      seen_res.total       = m_axis_tdata[106:75];
      seen_res.scaled      = m_axis_tdata[170:107];
      if (angles_due.size() == 0) begin
        $error("result item for slot %0d with no frame pending", seen_res.slot);
        bad_fields++;
      end else begin
        due_res = angles_due.pop_front();
        check_field("motor_slot", due_res.slot, seen_res.slot);
        check_field("encoder_value", due_res.encoder, seen_res.encoder);
        check_field("speed_value", due_res.speed, seen_res.speed);
        check_field("current_value", due_res.current, seen_res.current);
        check_field("temperature_value", due_res.temperature, seen_res.temperature);
        check_field("turn_count", due_res.turns, seen_res.turns);
        check_field("unwrapped_angle", due_res.total, seen_res.total);
        check_field("scaled_angle", due_res.scaled, seen_res.scaled);
      end
    end
  end

  // stimulus and end of run
  initial begin
    frame_row_t     frame_table[$];
    logic [IdW-1:0] phase_base  [6];
    int             phase_drift [6];
    int             phase_gap   [6];
    phase_base  = '{11'd513, 11'd0, 11'd2047, 11'd2044, 11'd1024, 11'd0};
    phase_drift = '{1, -1, 0, 1, -1, 0};
    phase_gap   = '{4, 0, 8, 2, 6, 3};
    phase_base[5] = IdW'($urandom_range(0, 2047));

    // directed frames under the reset base identifier
    // first frames of a slot read back zero turns and zero angle
    frame_table.push_back('{1'b0, 11'd513, 64'h0, 1'b1, 1'b1,
      '{3'd0, 16'd0, 16'sd0, 16'sd0, 8'd0, 19'sd0, 32'sd0, 64'sd0}});
    // just below the base and just past the four motors
    frame_table.push_back('{1'b0, 11'd512, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b1, 11'd517, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b1, 11'd2047, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd0, 64'hAAAA_5555_AAAA_5555, 1'b1, 1'b0,
      '{default: '0}});
    // payload of all ones
    frame_table.push_back('{1'b1, 11'd516, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
      '{3'd7, 16'hFFFF, -16'sd1, -16'sd1, 8'd255, 19'sd0, 32'sd0, 64'sd0}});
    // most negative speed, most positive current, byte seven ignored
    frame_table.push_back('{1'b1, 11'd514, 64'h1FFF_8000_7FFF_2AC3, 1'b1, 1'b1,
      '{3'd5, 16'd8191, 16'sh8000, 16'sh7FFF, 8'd42, 19'sd0, 32'sd0, 64'sd0}});
    frame_table.push_back('{1'b0, 11'd515, 64'h1000_0001_FFFF_0080, 1'b1, 1'b1,
      '{3'd2, 16'd4096, 16'sd1, -16'sd1, 8'd0, 19'sd0, 32'sd0, 64'sd0}});
    // slot 0 steps around the half-turn boundary, in both directions
    frame_table.push_back('{1'b0, 11'd513, {16'd8000, 48'h0123_4567_89AB}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd0, 48'h0123_4567_89AB}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd4096, 48'hFEDC_BA98_7654}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd0, 48'hFEDC_BA98_7654}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd4097, 48'h8000_8000_8000}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd0, 48'h7FFF_7FFF_7FFF}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd65535, 48'h0000_0000_0000}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b0, 11'd513, {16'd0, 48'hFFFF_FFFF_FFFF}, 1'b0, 1'b0,
      '{default: '0}});
    // big raw encoder jump down on slot 7, one bit past half a turn on slot 5
    frame_table.push_back('{1'b1, 11'd516, {16'd0, 48'h5A5A_A5A5_3C3C}, 1'b0, 1'b0,
      '{default: '0}});
    frame_table.push_back('{1'b1, 11'd514, {16'd4094, 48'hC3C3_1234_00FF}, 1'b0, 1'b0,
      '{default: '0}});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (frame_table[i]) send_frame(frame_table[i]);

    // random phases, base identifier changed only while idle; the turn count
    // limits lie about 2^18 turns away, far past what this run can drive
    for (int p = 0; p < 6; p++) begin
      settle();
      write_base_id(phase_base[p]);
      gap_max = phase_gap[p];
      send_random_frames(255, phase_drift[p]);
    end
    settle();

    if (bad_fields == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/mfau_pkg.sv
src/mfau_id_match.sv
src/motor_feedback_angle_unwrap.sv
bench/motor_feedback_angle_unwrap_test.sv
